/* src/point_plane_projection_defines.svh */
// Assertion helpers for the projection block.
`ifndef POINT_PLANE_PROJECTION_DEFINES_SVH
`define POINT_PLANE_PROJECTION_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define PPP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PPP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ppp_pkg.sv */
package ppp_pkg;

   localparam int AXES       = 3;
   localparam int CRD_W      = 32;              // Q16.16 coordinate
   localparam int DIF_W      = CRD_W + 1;       // coordinate difference
   localparam int XP_W       = 2 * DIF_W;       // cross product term
   localparam int NRM_W      = XP_W + 1;        // normal component
   localparam int ND_W       = NRM_W + DIF_W;   // n_i * d_i
   localparam int NS_W       = 2 * NRM_W;       // n_i * n_i
   localparam int NUM_W      = ND_W + 2;        // n . d
   localparam int NN_W       = NS_W + 2;        // |n|^2
   localparam int PRD_W      = NUM_W + NRM_W;   // n_i * num
   localparam int QUO_W      = 34;              // |quotient| < 2^33
   localparam int SUM_W      = QUO_W + 2;       // q_i +/- quotient
   localparam int MUL_STAGES = 4;

   localparam int REQ_W      = 4 * AXES * CRD_W;
   localparam int RSP_W      = AXES * CRD_W;
   localparam int USR_W      = 2;
   localparam int USR_DEGEN  = 0;
   localparam int USR_SAT    = 1;

endpackage

/* src/ppp_delay.sv */
module ppp_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         en,
   input  logic [W-1:0] din,
   output logic [W-1:0] dout
);

   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

/* src/ppp_mul.sv */
// Signed multiplier, b taken in NSTG slices, one slice per stage.
module ppp_mul #(
   parameter int WA   = 67,
   parameter int WB   = 33,
   parameter int NSTG = 4
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);

   localparam int CH  = (WB + NSTG - 1) / NSTG;
   localparam int WBP = CH * NSTG;
   localparam int WP  = WA + WBP;
   localparam int WPR = WA + CH + 1;

   logic signed [WBP-1:0] bx;
   logic signed [WA-1:0]  a_ff   [NSTG-1];
   logic signed [WBP-1:0] b_ff   [NSTG-1];
   logic signed [WP-1:0]  acc_ff [NSTG];

   assign bx = WBP'(b);

   for (genvar k = 0; k < NSTG; k++) begin : g_stg
      logic signed [WA-1:0]  a_src;
      logic signed [WBP-1:0] b_src;
      logic signed [WP-1:0]  acc_src;
      logic signed [CH:0]    slice;
      logic signed [WPR-1:0] prod;
      logic signed [WP-1:0]  acc_in;

      if (k == 0) begin : g_first
         assign a_src   = a;
         assign b_src   = bx;
         assign acc_src = '0;
      end else begin : g_next
         assign a_src   = a_ff[k-1];
         assign b_src   = b_ff[k-1];
         assign acc_src = acc_ff[k-1];
      end

      // top slice carries the sign, the rest are unsigned
      if (k == NSTG - 1) begin : g_top
         assign slice = {b_src[WBP-1], b_src[k*CH +: CH]};
      end else begin : g_low
         assign slice = {1'b0, b_src[k*CH +: CH]};
      end

      assign prod   = a_src * slice;
      assign acc_in = acc_src + (WP'(prod) <<< (k * CH));

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[k] <= acc_in;
         end
      end

      if (k < NSTG - 1) begin : g_pass
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[k] <= a_src;
               b_ff[k] <= b_src;
            end
         end
      end
   end

   assign p = acc_ff[NSTG-1][WA+WB-1:0];

endmodule

/* src/ppp_div.sv */
// Restoring divider, one quotient bit per stage, three lanes on one divisor.
module ppp_div import ppp_pkg::*; (
   input  logic                             clock,
   input  logic                             en,
   input  logic [AXES-1:0][PRD_W-1:0]       dend,
   input  logic [NN_W-1:0]                  dsor,
   output logic [AXES-1:0][QUO_W-1:0]       quo
);

   localparam int STEPS = QUO_W;

   logic [AXES-1:0][NN_W-1:0]  rem_ff  [STEPS-1];
   logic [AXES-1:0][QUO_W-1:0] lq_ff   [STEPS];
   logic [NN_W-1:0]            dsor_ff [STEPS-1];

   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic [AXES-1:0][NN_W-1:0]  rem_src;
      logic [AXES-1:0][QUO_W-1:0] lq_src;
      logic [NN_W-1:0]            dv_src;
      logic [AXES-1:0][NN_W:0]    trial;
      logic [AXES-1:0][NN_W:0]    diff;
      logic [AXES-1:0][NN_W-1:0]  rem_in;
      logic [AXES-1:0][QUO_W-1:0] lq_in;

      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < AXES; l++) begin
               rem_src[l] = NN_W'(dend[l][PRD_W-1:QUO_W]);
               lq_src[l]  = dend[l][QUO_W-1:0];
            end
         end
         assign dv_src = dsor;
      end else begin : g_next
         assign rem_src = rem_ff[s-1];
         assign lq_src  = lq_ff[s-1];
         assign dv_src  = dsor_ff[s-1];
      end

      // lq shifts dividend bits out at the top and quotient bits in below
      always_comb begin
         for (int l = 0; l < AXES; l++) begin
            trial[l] = {rem_src[l], lq_src[l][QUO_W-1]};
            diff[l]  = trial[l] - {1'b0, dv_src};
            if (trial[l] >= {1'b0, dv_src}) begin
               rem_in[l] = diff[l][NN_W-1:0];
               lq_in[l]  = {lq_src[l][QUO_W-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[l][NN_W-1:0];
               lq_in[l]  = {lq_src[l][QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lq_ff[s] <= lq_in;
         end
      end

      if (s < STEPS - 1) begin : g_keep
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s]  <= rem_in;
               dsor_ff[s] <= dv_src;
            end
         end
      end
   end

   assign quo = lq_ff[STEPS-1];

endmodule

/* src/point_plane_projection.sv */
// Orthogonal projection of a point onto the plane through three points.
//
// Input stream (req_*): one beat carries the query point q and plane
// points a, b, c, all signed Q16.16. Output stream (rsp_*): one beat
// per input beat, in order, with the projected point and two flags.
// The pipe has 48 register stages, the first loaded at the accepting
// edge; a new beat is taken every cycle unless the receiver stalls.
// Those stages are the 34-stage restoring divider (one quotient bit
// per stage), two 4-stage sliced multipliers and the difference,
// cross product, normal, sum, abs and output stages around them.
// Collinear plane points (|n|^2 = 0) give q back with degenerate set.
// A result outside 32 bits is clamped and saturated set.
// Reset (synchronous, active high) clears every valid bit; beats in
// flight are dropped. When the receiver stalls with a beat waiting,
// the whole pipe holds and req_tready drops in the same cycle, so no
// beat is lost or repeated; it moves again once rsp_tready returns.
`include "point_plane_projection_defines.svh"

module point_plane_projection import ppp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // query_x, query_y, query_z, plane_a_x, plane_a_y, plane_a_z,
   // plane_b_x, plane_b_y, plane_b_z, plane_c_x, plane_c_y, plane_c_z
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // proj_x, proj_y, proj_z
   output logic [RSP_W-1:0] rsp_tdata,
   // degenerate, saturated
   output logic [USR_W-1:0] rsp_tuser
);

   // pipeline positions (register stage at which a value is registered, stage 1 loaded at acceptance)
   localparam int P_N   = 3;
   localparam int P_SUM = P_N + MUL_STAGES + 1;
   localparam int P_DEG = P_SUM + 1;
   localparam int P_ABS = P_SUM + MUL_STAGES + 1;
   localparam int P_DIV = P_ABS + QUO_W;
   localparam int LAT   = P_DIV + 1;

   logic             en;
   logic [LAT-1:0]   vld_ff;

   // global advance: the pipe moves unless the output beat is stuck
   assign en         = ~vld_ff[LAT-1] | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ---- stage 1: edge vectors v1 = c - a, v2 = b - a, d = a - q
   logic [AXES-1:0][CRD_W-1:0] q_in, q_ff;
   logic [AXES-1:0][DIF_W-1:0] v1_in, v1_ff, v2_in, v2_ff, d_in, d_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         logic [CRD_W-1:0] qa, aa, ba, ca;
         qa = req_tdata[i*CRD_W +: CRD_W];
         aa = req_tdata[(AXES+i)*CRD_W +: CRD_W];
         ba = req_tdata[(2*AXES+i)*CRD_W +: CRD_W];
         ca = req_tdata[(3*AXES+i)*CRD_W +: CRD_W];
         q_in[i]  = qa;
         v1_in[i] = {ca[CRD_W-1], ca} - {aa[CRD_W-1], aa};
         v2_in[i] = {ba[CRD_W-1], ba} - {aa[CRD_W-1], aa};
         d_in[i]  = {aa[CRD_W-1], aa} - {qa[CRD_W-1], qa};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff  <= q_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         d_ff  <= d_in;
      end
   end

   // ---- stage 2: the six cross product terms
   logic [5:0][XP_W-1:0] xp_in, xp_ff;

   always_comb begin
      xp_in[0] = $signed(v1_ff[1]) * $signed(v2_ff[2]);
      xp_in[1] = $signed(v2_ff[1]) * $signed(v1_ff[2]);
      xp_in[2] = $signed(v2_ff[0]) * $signed(v1_ff[2]);
      xp_in[3] = $signed(v1_ff[0]) * $signed(v2_ff[2]);
      xp_in[4] = $signed(v1_ff[0]) * $signed(v2_ff[1]);
      xp_in[5] = $signed(v2_ff[0]) * $signed(v1_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xp_ff <= xp_in;
      end
   end

   // ---- stage 3: normal n = v1 x v2
   logic [AXES-1:0][NRM_W-1:0] n_in, n_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         n_in[i] = {xp_ff[2*i][XP_W-1], xp_ff[2*i]}
                 - {xp_ff[2*i+1][XP_W-1], xp_ff[2*i+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff <= n_in;
      end
   end

   // ---- stages 4..7: n_i * d_i and n_i * n_i
   logic [AXES-1:0][DIF_W-1:0] d_al;
   logic [AXES-1:0][ND_W-1:0]  nd_p;
   logic [AXES-1:0][NS_W-1:0]  ns_p;

   ppp_delay #(.W(AXES*DIF_W), .DEPTH(P_N-1)) u_d_dly (
      .clock (clock), .en (en), .din (d_ff), .dout (d_al)
   );

   for (genvar i = 0; i < AXES; i++) begin : g_mul1
      ppp_mul #(.WA(NRM_W), .WB(DIF_W), .NSTG(MUL_STAGES)) u_nd (
         .clock (clock), .en (en), .a (n_ff[i]), .b (d_al[i]), .p (nd_p[i])
      );
      ppp_mul #(.WA(NRM_W), .WB(NRM_W), .NSTG(MUL_STAGES)) u_ns (
         .clock (clock), .en (en), .a (n_ff[i]), .b (n_ff[i]), .p (ns_p[i])
      );
   end

   // ---- stage 8: num = n . d, nn = |n|^2 (squares are never negative)
   logic [NUM_W-1:0] num_in, num_ff;
   logic [NN_W-1:0]  nn_in, nn_ff;

   always_comb begin
      num_in = '0;
      nn_in  = '0;
      for (int i = 0; i < AXES; i++) begin
         num_in = num_in + {{(NUM_W-ND_W){nd_p[i][ND_W-1]}}, nd_p[i]};
         nn_in  = nn_in + {{(NN_W-NS_W){1'b0}}, ns_p[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         nn_ff  <= nn_in;
      end
   end

   // ---- stage 9: collinear plane points
   logic degen_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         degen_ff <= (nn_ff == '0);
      end
   end

   // ---- stages 9..12: n_i * num
   logic [AXES-1:0][NRM_W-1:0] n_al;
   logic [AXES-1:0][PRD_W-1:0] pr_p;

   ppp_delay #(.W(AXES*NRM_W), .DEPTH(P_SUM-P_N)) u_n_dly (
      .clock (clock), .en (en), .din (n_ff), .dout (n_al)
   );

   for (genvar i = 0; i < AXES; i++) begin : g_mul2
      ppp_mul #(.WA(NUM_W), .WB(NRM_W), .NSTG(MUL_STAGES)) u_pr (
         .clock (clock), .en (en), .a (num_ff), .b (n_al[i]), .p (pr_p[i])
      );
   end

   // ---- stage 13: sign and magnitude of the dividend
   logic [AXES-1:0]            neg_in, neg_ff;
   logic [AXES-1:0][PRD_W-1:0] mag_in, mag_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         neg_in[i] = pr_p[i][PRD_W-1];
         mag_in[i] = neg_in[i] ? (~pr_p[i] + 1'b1) : pr_p[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
   end

   // ---- stages 14..47: truncating division by |n|^2
   logic [NN_W-1:0]            nn_al;
   logic [AXES-1:0][QUO_W-1:0] quo;

   ppp_delay #(.W(NN_W), .DEPTH(P_ABS-P_SUM)) u_nn_dly (
      .clock (clock), .en (en), .din (nn_ff), .dout (nn_al)
   );

   ppp_div u_div (
      .clock (clock), .en (en), .dend (mag_ff), .dsor (nn_al), .quo (quo)
   );

   // side data brought level with the quotient
   logic [AXES-1:0]            neg_al;
   logic [AXES-1:0][CRD_W-1:0] q_al;
   logic                       degen_al;

   ppp_delay #(.W(AXES), .DEPTH(P_DIV-P_ABS)) u_neg_dly (
      .clock (clock), .en (en), .din (neg_ff), .dout (neg_al)
   );
   ppp_delay #(.W(AXES*CRD_W), .DEPTH(P_DIV-1)) u_q_dly (
      .clock (clock), .en (en), .din (q_ff), .dout (q_al)
   );
   ppp_delay #(.W(1), .DEPTH(P_DIV-P_DEG)) u_deg_dly (
      .clock (clock), .en (en), .din (degen_ff), .dout (degen_al)
   );

   // ---- stage 48: q_i + signed quotient, clamp, output register
   logic [AXES-1:0][SUM_W-1:0] sum;
   logic [AXES-1:0][CRD_W-1:0] res;
   logic [AXES-1:0]            clip;
   logic [RSP_W-1:0]           rsp_data_in, rsp_data_ff;
   logic [USR_W-1:0]           rsp_user_in, rsp_user_ff;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         logic [SUM_W-1:0] qx, qq;
         qx = {{(SUM_W-CRD_W){q_al[i][CRD_W-1]}}, q_al[i]};
         qq = {{(SUM_W-QUO_W){1'b0}}, quo[i]};
         sum[i] = neg_al[i] ? (qx - qq) : (qx + qq);
         if ((&sum[i][SUM_W-1:CRD_W-1]) | ~(|sum[i][SUM_W-1:CRD_W-1])) begin
            res[i]  = sum[i][CRD_W-1:0];
            clip[i] = 1'b0;
         end else begin
            res[i]  = sum[i][SUM_W-1] ? {1'b1, {(CRD_W-1){1'b0}}}
                                      : {1'b0, {(CRD_W-1){1'b1}}};
            clip[i] = 1'b1;
         end
      end
      rsp_data_in = degen_al ? q_al : res;
      rsp_user_in[USR_DEGEN] = degen_al;
      rsp_user_in[USR_SAT]   = ~degen_al & (|clip);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   // ---- checks
   `PPP_ASSERT_SAME(a_stall_holds_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "input taken while output stalled")
   `PPP_ASSERT_SAME(a_quo_bound, clock, reset, vld_ff[P_DIV-1] && !degen_al, !(quo[0][QUO_W-1] || quo[1][QUO_W-1] || quo[2][QUO_W-1]), "quotient out of range")
   `PPP_ASSERT_NEXT(a_degen_no_sat, clock, reset, en && vld_ff[LAT-2] && degen_al, rsp_tvalid && !rsp_tuser[USR_SAT], "saturated on degenerate beat")

endmodule

/* test/point_plane_projection_tb.sv */
`timescale 1ns / 100ps

module point_plane_projection_tb import ppp_pkg::*;;

   typedef logic signed [CRD_W-1:0] coord_type;
   typedef coord_type point_set_type [4*AXES];      // q, a, b, c; x, y, z each

   typedef struct {
      coord_type proj [AXES];
      logic      degenerate;
      logic      saturated;
   } projection_type;

   localparam coord_type CRD_MAX = 32'sh7fffffff;
   localparam coord_type CRD_MIN = 32'sh80000000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;   // query x,y,z, plane a x,y,z, b x,y,z, c x,y,z
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;   // proj_x, proj_y, proj_z
   logic [USR_W-1:0] rsp_tuser;   // degenerate, saturated

   logic [REQ_W-1:0] pending_beats [$];
   projection_type   expected_projections [$];
   int               beats_sent = 0;
   int               results_seen = 0;
   int               mismatches = 0;
   bit               hold_done;
   int               hold_cycles;

   point_plane_projection u_top (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Exact projection: every intermediate fits easily in 256 signed bits
   function automatic projection_type project_point(logic [REQ_W-1:0] beat);
      logic signed [255:0] q [AXES];
      logic signed [255:0] a [AXES];
      logic signed [255:0] v1 [AXES];
      logic signed [255:0] v2 [AXES];
      logic signed [255:0] n [AXES];
      logic signed [255:0] num;
      logic signed [255:0] nn;
      logic signed [255:0] sum;
      projection_type      r;
      num = 0;
      nn  = 0;
      r.degenerate = 1'b0;
      r.saturated  = 1'b0;
      for (int i = 0; i < AXES; i++) begin
         q[i]  = coord_type'(beat[CRD_W*i +: CRD_W]);
         a[i]  = coord_type'(beat[CRD_W*(AXES+i) +: CRD_W]);
         v2[i] = coord_type'(beat[CRD_W*(2*AXES+i) +: CRD_W]);
         v1[i] = coord_type'(beat[CRD_W*(3*AXES+i) +: CRD_W]);
         v1[i] = v1[i] - a[i];   // c - a
         v2[i] = v2[i] - a[i];   // b - a
      end
      n[0] = v1[1] * v2[2] - v2[1] * v1[2];
      n[1] = v2[0] * v1[2] - v1[0] * v2[2];
      n[2] = v1[0] * v2[1] - v2[0] * v1[1];
      for (int i = 0; i < AXES; i++) begin
         num = num + n[i] * (a[i] - q[i]);
         nn  = nn + n[i] * n[i];
      end
      for (int i = 0; i < AXES; i++) begin
         if (nn == 0) begin
            r.proj[i]    = coord_type'(q[i]);
            r.degenerate = 1'b1;
         end else begin
            sum = q[i] + (n[i] * num) / nn;   // SV division truncates toward zero
            if (sum > CRD_MAX) begin
               r.proj[i]   = CRD_MAX;
               r.saturated = 1'b1;
            end else if (sum < CRD_MIN) begin
               r.proj[i]   = CRD_MIN;
               r.saturated = 1'b1;
            end else begin
               r.proj[i] = coord_type'(sum);
            end
         end
      end
      return r;
   endfunction

   function automatic logic [REQ_W-1:0] pack_points(point_set_type p);
      logic [REQ_W-1:0] beat;
      for (int k = 0; k < 4*AXES; k++)
         beat[CRD_W*k +: CRD_W] = p[k];
      return beat;
   endfunction

   // small signed value, magnitude below 2^bits
   function automatic coord_type small_coord(int bits);
      return coord_type'($signed($urandom)) >>> (CRD_W - bits);
   endfunction

   function automatic logic [REQ_W-1:0] random_points();
      point_set_type p;
      coord_type     dir [AXES];
      int            mode;
      int            bits;
      int            src;
      mode = $urandom_range(0, 9);
      bits = $urandom_range(2, 31);
      for (int k = 0; k < 4*AXES; k++)
         p[k] = (mode < 4) ? coord_type'($urandom) : small_coord(bits);
      case (mode)
         7: begin
            // collinear plane points: a, a+d, a+2d
            for (int i = 0; i < AXES; i++) begin
               dir[i]        = small_coord(20);
               p[AXES+i]     = small_coord(28);
               p[2*AXES+i]   = p[AXES+i] + dir[i];
               p[3*AXES+i]   = p[AXES+i] + 2 * dir[i];
            end
         end
         8: begin
            // two coincident plane points: c on a or on b
            src = $urandom_range(1, 2);
            for (int i = 0; i < AXES; i++)
               p[3*AXES+i] = p[src*AXES+i];
         end
         9: begin
            // query far off a small plane, pushes results towards the rails
            for (int i = 0; i < AXES; i++)
               p[i] = $urandom_range(0, 1) ? CRD_MAX - small_coord(8)
                                           : CRD_MIN + small_coord(8);
         end
         default: ;
      endcase
      return pack_points(p);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got,
               want);
      mismatches++;
   endtask

   // Directed beats: rails, flat planes, collinear and coincident points
   initial begin
      point_set_type p;
      for (int v = 0; v < 6; v++) begin
         for (int k = 0; k < 4*AXES; k++)
            case (v)
               0: p[k] = '0;
               1: p[k] = CRD_MAX;
               2: p[k] = CRD_MIN;
               3: p[k] = k[0] ? CRD_MAX : CRD_MIN;
               4: p[k] = k[1] ? CRD_MIN : CRD_MAX;
               default: p[k] = coord_type'(k * 32'sh10000);   // collinear ramp
            endcase
         pending_beats.push_back(pack_points(p));
      end
      // z = 0 plane, query at each rail: projection drops z
      foreach (p[k]) p[k] = '0;
      p[2*AXES] = 32'sh10000;
      p[3*AXES+1] = 32'sh10000;
      for (int v = 0; v < 4; v++) begin
         p[0] = v[0] ? CRD_MAX : CRD_MIN;
         p[1] = v[1] ? CRD_MIN : CRD_MAX;
         p[2] = v[0] ? CRD_MAX : CRD_MIN;
         pending_beats.push_back(pack_points(p));
      end
      // extreme plane spanning full range, query at opposite corner: projects exactly onto the rail
      foreach (p[k]) p[k] = CRD_MIN;
      p[2*AXES] = CRD_MAX;
      p[3*AXES+1] = CRD_MAX;
      p[0] = CRD_MAX; p[1] = CRD_MAX; p[2] = CRD_MAX;
      pending_beats.push_back(pack_points(p));
      // tilted plane x+y+z = 0 with large queries along its normal, both project to the origin
      foreach (p[k]) p[k] = '0;
      p[2*AXES] = CRD_MAX; p[2*AXES+1] = CRD_MIN + 1;
      p[3*AXES+1] = CRD_MAX; p[3*AXES+2] = CRD_MIN + 1;
      p[0] = CRD_MIN; p[1] = CRD_MIN; p[2] = CRD_MIN;
      pending_beats.push_back(pack_points(p));
      p[0] = CRD_MAX; p[1] = CRD_MAX; p[2] = CRD_MAX;
      pending_beats.push_back(pack_points(p));
      for (int j = 0; j < 700; j++)
         pending_beats.push_back(random_points());
   end

   // Driver: 9% idle, none in a stretch, and one pause to drain the pipe
   always @(posedge clock) begin
      logic offer;
      int   sent;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         // count including a beat taken at this edge
         sent  = beats_sent + ((req_tvalid && req_tready) ? 1 : 0);
         offer = pending_beats.size() > 0;
         if (sent == 250 && expected_projections.size() > 0)
            offer = 1'b0;
         else if (!(sent >= 400 && sent < 520) && $urandom_range(0, 99) < 9)
            offer = 1'b0;
         if (offer)
            req_tdata <= pending_beats.pop_front();
         req_tvalid <= offer;
         beats_sent <= sent;
      end
   end

   // Receiver: 9% stall, none in a stretch, one long hold to back the pipe up
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= 0;
         hold_done   <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= hold_cycles == 1;
      end else if (!hold_done && results_seen == 120) begin
         hold_done   <= 1'b1;
         hold_cycles <= 300;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= (results_seen >= 450 && results_seen < 570) ||
                       $urandom_range(0, 99) >= 9;
      end
   end

   // Monitor: predict on input beats, check output beats in order
   always @(posedge clock) begin
      projection_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_projections.push_back(project_point(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_projections.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata[CRD_W-1:0], '0);
            end else begin
               want = expected_projections.pop_front();
               for (int i = 0; i < AXES; i++)
                  if (rsp_tdata[CRD_W*i +: CRD_W] !== want.proj[i])
                     report_mismatch($sformatf("proj[%0d]", i),
                                     rsp_tdata[CRD_W*i +: CRD_W], want.proj[i]);
               if (rsp_tuser[USR_DEGEN] !== want.degenerate)
                  report_mismatch("degenerate", rsp_tuser[USR_DEGEN], want.degenerate);
               if (rsp_tuser[USR_SAT] !== want.saturated)
                  report_mismatch("saturated", rsp_tuser[USR_SAT], want.saturated);
            end
            results_seen <= results_seen + 1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_projections.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_projections.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

endmodule
